// ===== src/psca_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PPM stream contrast adjuster.
// Holds the beat types, status codes and header character constants; no dependencies.
package psca_pkg;

  localparam int STATUS_W = 3;
  localparam int PIX_W    = 8;
  localparam int DIM_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int MVAL_W   = 16;

  localparam logic [STATUS_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [STATUS_W-1:0] ERR_MAGIC  = 3'd1;
  localparam logic [STATUS_W-1:0] ERR_MAXVAL = 3'd2;
  localparam logic [STATUS_W-1:0] ERR_SIZE   = 3'd3;
  localparam logic [STATUS_W-1:0] ERR_DIM    = 3'd4;

  localparam logic [7:0] CH_MAGIC0 = 8'h50;
  localparam logic [7:0] CH_MAGIC1 = 8'h36;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [MVAL_W-1:0] MAXVAL_OK = 16'd255;
  localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 16'sd256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } byte_beat_t;

  typedef struct packed {
    logic                has_pixel;
    logic [PIX_W-1:0]    pixel_value;
    logic                end_of_file;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
  } pix_beat_t;

endpackage

// ===== src/psca_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the pixel result streams.
// Depends on psca_pkg for the beat types.
interface psca_byte_if;
  logic                 valid;
  logic                 ready;
  psca_pkg::byte_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psca_pix_if;
  logic                valid;
  logic                ready;
  psca_pkg::pix_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/psca_pixel_adjust.sv =====
`timescale 1ns / 1ps
// Combinational contrast stretch of one color component around mid-gray.
// Depends on psca_pkg for widths.
module psca_pixel_adjust #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic signed [psca_pkg::GAIN_W-1:0] gain,
  input  logic [psca_pkg::PIX_W-1:0]         pixel,
  output logic [psca_pkg::PIX_W-1:0]         value
);

  localparam int PROD_W = psca_pkg::GAIN_W + 10;
  localparam int NW     = PROD_W + GAIN_FRAC_BITS + 1;
  localparam logic signed [NW-1:0] OFFSET = NW'(255) <<< GAIN_FRAC_BITS;

  logic signed [9:0]        diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [NW-1:0]     num;
  logic [NW-1:0]            quo;

  always_comb begin
    diff = $signed({2'b00, pixel}) + $signed({2'b00, pixel}) - 10'sd255;
    prod = diff * gain;
    num  = NW'(prod) + OFFSET;
    quo  = NW'(num >>> (GAIN_FRAC_BITS + 1));
    if (num[NW-1]) begin
      value = '0;
    end else if (quo > NW'(255)) begin
      value = 8'd255;
    end else begin
      value = quo[psca_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== src/ppm_stream_contrast_adjust.sv =====
`timescale 1ns / 1ps
// Top level of the PPM (P6) stream contrast adjuster: header parser, byte counter, result register.
// Depends on psca_pkg, psca_ifs and psca_pixel_adjust.
//
// file_bytes carries one file byte per beat with an is_last flag. The header ("P6", width,
// height, maxval 255, one separator byte) yields no beats; each pixel byte after it yields
// one beat on pixels with the stretched value. The last byte of a file always yields a beat
// with end_of_file, the status code and the parsed width and height; parsing then restarts.
// Bytes after an error are drained with no output until the last byte.
// cfg_we/cfg_wdata load the signed Q8.8 gain; write it only while no beat is in flight.
// An accepted byte is held in the input register and its result beat is registered in the output
// register. Throughput: one byte per cycle unless the output stalls; the input register and the
// output register are each one deep; state update and the 10x16 pixel multiply are combinational.
// The pixel count width*height*3 is formed in the cycle that consumes the maxval separator.
// Reset (synchronous) empties both registers, sets the gain to unity and restarts parsing.
// When pixels.ready is low with a beat held, the held beat stays stable; bytes that make no
// beat still advance, and file_bytes.ready drops once a byte needing a result must wait.
module ppm_stream_contrast_adjust #(
  parameter int DIM_BITS       = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic signed [psca_pkg::GAIN_W-1:0] cfg_wdata,
  psca_byte_if.sink                         file_bytes,
  psca_pix_if.source                        pixels
);

  localparam int RW = 2 * DIM_BITS + 2;

  localparam logic [3:0] PH_MAGIC0 = 4'd0;
  localparam logic [3:0] PH_MAGIC1 = 4'd1;
  localparam logic [3:0] PH_SKIP_W = 4'd2;
  localparam logic [3:0] PH_DIG_W  = 4'd3;
  localparam logic [3:0] PH_SKIP_H = 4'd4;
  localparam logic [3:0] PH_DIG_H  = 4'd5;
  localparam logic [3:0] PH_SKIP_M = 4'd6;
  localparam logic [3:0] PH_DIG_M  = 4'd7;
  localparam logic [3:0] PH_PIXELS = 4'd8;
  localparam logic [3:0] PH_DRAIN  = 4'd9;

  logic signed [psca_pkg::GAIN_W-1:0] gain;

  logic                 in_v;
  psca_pkg::byte_beat_t in_q;
  logic                 out_v;
  psca_pkg::pix_beat_t  out_q;

  logic [3:0]                    phase, phase_next;
  logic [DIM_BITS-1:0]           width_acc, width_acc_next;
  logic [DIM_BITS-1:0]           height_acc, height_acc_next;
  logic [psca_pkg::MVAL_W-1:0]   maxval_acc, maxval_acc_next;
  logic [RW-1:0]                 remaining, remaining_next;
  logic [psca_pkg::STATUS_W-1:0] err, err_next;

  logic [7:0]                    b;
  logic                          b_space, b_digit;
  logic [3:0]                    digit;
  logic [DIM_BITS+3:0]           w_ext, h_ext;
  logic [psca_pkg::MVAL_W+3:0]   m_ext;
  logic [2*DIM_BITS-1:0]         wh;
  logic [RW-1:0]                 area, count3;
  logic                          do_fail, end_hdr, has_pix, emit, advance;
  logic [psca_pkg::STATUS_W-1:0] fail_code, status;
  logic [psca_pkg::PIX_W-1:0]    pix_val;

  psca_pixel_adjust #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_adjust (
    .gain  (gain),
    .pixel (in_q.data_byte),
    .value (pix_val)
  );

  always_comb begin
    b       = in_q.data_byte;
    b_space = b inside {psca_pkg::CH_SPACE, psca_pkg::CH_NL};
    b_digit = b inside {[psca_pkg::CH_ZERO:psca_pkg::CH_NINE]};
    digit   = b[3:0];
    w_ext   = {1'b0, width_acc, 3'b000} + {3'b000, width_acc, 1'b0} +
              (DIM_BITS + 4)'(digit);
    h_ext   = {1'b0, height_acc, 3'b000} + {3'b000, height_acc, 1'b0} +
              (DIM_BITS + 4)'(digit);
    m_ext   = {1'b0, maxval_acc, 3'b000} + {3'b000, maxval_acc, 1'b0} + 20'(digit);
    wh      = width_acc * height_acc;
    area    = {2'b00, wh};
    count3  = {area[RW-2:0], 1'b0} + area;
  end

  always_comb begin
    phase_next      = phase;
    width_acc_next  = width_acc;
    height_acc_next = height_acc;
    maxval_acc_next = maxval_acc;
    remaining_next  = remaining;
    err_next        = err;
    do_fail         = 1'b0;
    fail_code       = psca_pkg::ERR_NONE;
    end_hdr         = 1'b0;
    has_pix         = 1'b0;
    case (phase)
      PH_MAGIC0: begin
        if (b == psca_pkg::CH_MAGIC0) begin
          phase_next = PH_MAGIC1;
        end else begin
          do_fail   = 1'b1;
          fail_code = psca_pkg::ERR_MAGIC;
        end
      end
      PH_MAGIC1: begin
        if (b == psca_pkg::CH_MAGIC1) begin
          phase_next = PH_SKIP_W;
        end else begin
          do_fail   = 1'b1;
          fail_code = psca_pkg::ERR_MAGIC;
        end
      end
      PH_SKIP_W, PH_DIG_W: begin
        if (b_space) begin
          phase_next = (phase == PH_SKIP_W) ? PH_SKIP_W : PH_SKIP_H;
        end else if (b_digit) begin
          phase_next = PH_DIG_W;
          if (w_ext[DIM_BITS+3:DIM_BITS] != 4'd0) begin
            do_fail   = 1'b1;
            fail_code = psca_pkg::ERR_DIM;
          end else begin
            width_acc_next = w_ext[DIM_BITS-1:0];
          end
        end else begin
          end_hdr = 1'b1;
        end
      end
      PH_SKIP_H, PH_DIG_H: begin
        if (b_space) begin
          phase_next = (phase == PH_SKIP_H) ? PH_SKIP_H : PH_SKIP_M;
        end else if (b_digit) begin
          phase_next = PH_DIG_H;
          if (h_ext[DIM_BITS+3:DIM_BITS] != 4'd0) begin
            do_fail   = 1'b1;
            fail_code = psca_pkg::ERR_DIM;
          end else begin
            height_acc_next = h_ext[DIM_BITS-1:0];
          end
        end else begin
          end_hdr = 1'b1;
        end
      end
      PH_SKIP_M, PH_DIG_M: begin
        if (b_digit) begin
          phase_next      = PH_DIG_M;
          maxval_acc_next = (m_ext[19:16] != 4'd0) ? '1 : m_ext[15:0];
        end else if (!(b_space && phase == PH_SKIP_M)) begin
          end_hdr = 1'b1;
        end
      end
      PH_PIXELS: begin
        if (remaining == '0) begin
          do_fail   = 1'b1;
          fail_code = psca_pkg::ERR_SIZE;
        end else begin
          remaining_next = remaining - RW'(1);
          has_pix        = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (end_hdr) begin
      if (maxval_acc != psca_pkg::MAXVAL_OK) begin
        do_fail   = 1'b1;
        fail_code = psca_pkg::ERR_MAXVAL;
      end else begin
        remaining_next = count3;
        phase_next     = PH_PIXELS;
      end
    end
    if (do_fail) begin
      phase_next = PH_DRAIN;
      if (err == psca_pkg::ERR_NONE) begin
        err_next = fail_code;
      end
    end

    if (err_next != psca_pkg::ERR_NONE) begin
      status = err_next;
    end else if (phase_next == PH_MAGIC0 || phase_next == PH_MAGIC1) begin
      status = psca_pkg::ERR_MAGIC;
    end else if (phase_next != PH_PIXELS || remaining_next != '0) begin
      status = psca_pkg::ERR_SIZE;
    end else begin
      status = psca_pkg::ERR_NONE;
    end

    emit    = has_pix || in_q.is_last;
    advance = in_v && (!emit || !out_v || pixels.ready);
  end

  assign file_bytes.ready = !in_v || advance;
  assign pixels.valid     = out_v;
  assign pixels.data      = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= psca_pkg::GAIN_UNITY;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (file_bytes.valid && file_bytes.ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
    if (file_bytes.valid && file_bytes.ready) begin
      in_q <= file_bytes.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC0;
      width_acc  <= '0;
      height_acc <= '0;
      maxval_acc <= '0;
      remaining  <= '0;
      err        <= psca_pkg::ERR_NONE;
    end else if (advance) begin
      if (in_q.is_last) begin
        phase      <= PH_MAGIC0;
        width_acc  <= '0;
        height_acc <= '0;
        maxval_acc <= '0;
        remaining  <= '0;
        err        <= psca_pkg::ERR_NONE;
      end else begin
        phase      <= phase_next;
        width_acc  <= width_acc_next;
        height_acc <= height_acc_next;
        maxval_acc <= maxval_acc_next;
        remaining  <= remaining_next;
        err        <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance && emit) begin
      out_v <= 1'b1;
    end else if (pixels.ready) begin
      out_v <= 1'b0;
    end
    if (advance && emit) begin
      out_q.has_pixel    <= has_pix;
      out_q.pixel_value  <= has_pix ? pix_val : '0;
      out_q.end_of_file  <= in_q.is_last;
      out_q.status       <= in_q.is_last ? status : psca_pkg::ERR_NONE;
      out_q.image_width  <= in_q.is_last ? psca_pkg::DIM_W'(width_acc_next) : '0;
      out_q.image_height <= in_q.is_last ? psca_pkg::DIM_W'(height_acc_next) : '0;
    end
  end

endmodule

// ===== src/psca_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the PPM stream contrast adjuster, bound to the top level.
// Depends on psca_pkg for the result beat type and status codes.
module psca_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input psca_pkg::pix_beat_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_beat_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.has_pixel || out_data.end_of_file)
    else $error("result beat with neither pixel nor end of file");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.end_of_file |->
      out_data.status == psca_pkg::ERR_NONE && out_data.image_width == '0 &&
      out_data.image_height == '0)
    else $error("file summary fields set on a mid-file beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == psca_pkg::ERR_NONE ||
      out_data.status == psca_pkg::ERR_MAGIC || out_data.status == psca_pkg::ERR_MAXVAL ||
      out_data.status == psca_pkg::ERR_SIZE || out_data.status == psca_pkg::ERR_DIM) &&
      (out_data.has_pixel || out_data.pixel_value == '0))
    else $error("bad status code or stray pixel value");

endmodule

bind ppm_stream_contrast_adjust psca_checker u_psca_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pixels.valid),
  .out_ready (pixels.ready),
  .out_data  (pixels.data)
);

// ===== verif/tb_ppm_stream_contrast_adjust.sv =====
`timescale 1ns / 1ps
// Testbench for ppm_stream_contrast_adjust: drives P6 files byte by byte and checks every
// beat against a built-in predictor or fixed beats. Depends on psca_pkg, psca_ifs and the RTL.
module tb_ppm_stream_contrast_adjust;

  localparam int     GAIN_FRAC  = 8;
  localparam longint DIM_MAX    = (64'd1 << 16) - 1;
  localparam int     PHASE_CNT  = 8;
  localparam int     PHASE_BYTES = 190;

  localparam logic [3:0] HP_MAGIC0 = 4'd0;
  localparam logic [3:0] HP_MAGIC1 = 4'd1;
  localparam logic [3:0] HP_SKIP_W = 4'd2;
  localparam logic [3:0] HP_DIG_W  = 4'd3;
  localparam logic [3:0] HP_SKIP_H = 4'd4;
  localparam logic [3:0] HP_DIG_H  = 4'd5;
  localparam logic [3:0] HP_SKIP_M = 4'd6;
  localparam logic [3:0] HP_DIG_M  = 4'd7;
  localparam logic [3:0] HP_PIXELS = 4'd8;
  localparam logic [3:0] HP_DRAIN  = 4'd9;

  typedef struct {
    logic [7:0]          b;
    logic                last;
    bit                  fixed;
    psca_pkg::pix_beat_t beat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic signed [psca_pkg::GAIN_W-1:0] cfg_wdata;

  psca_byte_if file_bytes_if ();
  psca_pix_if  pixels_if ();

  ppm_stream_contrast_adjust u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .file_bytes (file_bytes_if),
    .pixels     (pixels_if)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [3:0]                         hp = HP_MAGIC0;
  longint                             wacc = 0;
  longint                             hacc = 0;
  longint                             mval = 0;
  longint                             pix_left = 0;
  logic [psca_pkg::STATUS_W-1:0]      err_q = psca_pkg::ERR_NONE;
  logic signed [psca_pkg::GAIN_W-1:0] gain_q = psca_pkg::GAIN_UNITY;

  psca_pkg::pix_beat_t pix_expect[$];
  dir_row_t            dir_rows[$];
  logic [7:0]          file_q[$];
  int                  err_cnt = 0;
  bit                  calm = 1'b0;
  int                  stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_dec(logic [7:0] b);
    return b >= psca_pkg::CH_ZERO && b <= psca_pkg::CH_NINE;
  endfunction

  function automatic void hdr_fail(logic [psca_pkg::STATUS_W-1:0] code);
    if (err_q == psca_pkg::ERR_NONE) err_q = code;
    hp = HP_DRAIN;
  endfunction

  function automatic psca_pkg::pix_beat_t mk_beat(logic has, logic [7:0] pix, logic eof,
                                                  logic [psca_pkg::STATUS_W-1:0] st,
                                                  logic [15:0] w, logic [15:0] h);
    psca_pkg::pix_beat_t r;
    r.has_pixel    = has;
    r.pixel_value  = pix;
    r.end_of_file  = eof;
    r.status       = st;
    r.image_width  = w;
    r.image_height = h;
    return r;
  endfunction

  function automatic bit ppm_predict(input logic [7:0] b, input logic last,
                                     output psca_pkg::pix_beat_t r);
    bit                            pix_out;
    logic [7:0]                    pv;
    bit                            done;
    int                            n;
    longint                        v;
    longint                        num;
    logic [psca_pkg::STATUS_W-1:0] st;
    pix_out = 1'b0;
    pv = '0;
    r = '0;
    case (hp)
      HP_MAGIC0: begin
        if (b == psca_pkg::CH_MAGIC0) hp = HP_MAGIC1;
        else hdr_fail(psca_pkg::ERR_MAGIC);
      end
      HP_MAGIC1: begin
        if (b == psca_pkg::CH_MAGIC1) hp = HP_SKIP_W;
        else hdr_fail(psca_pkg::ERR_MAGIC);
      end
      HP_PIXELS: begin
        if (pix_left == 0) begin
          hdr_fail(psca_pkg::ERR_SIZE);
        end else begin
          pix_left--;
          pix_out = 1'b1;
          num = (2 * longint'(b) - 255) * longint'(gain_q) + 255 * (64'sd1 <<< GAIN_FRAC);
          if (num < 0) pv = 8'd0;
          else if ((num >>> (GAIN_FRAC + 1)) > 255) pv = 8'd255;
          else pv = 8'(num >>> (GAIN_FRAC + 1));
        end
      end
      HP_DRAIN: ;
      default: begin
        done = 1'b0;
        for (n = 0; n < 8 && !done; n++) begin
          case (hp)
            HP_SKIP_W, HP_SKIP_H, HP_SKIP_M: begin
              if (b == psca_pkg::CH_SPACE || b == psca_pkg::CH_NL) done = 1'b1;
              else hp = hp + 4'd1;
            end
            HP_DIG_W, HP_DIG_H: begin
              if (is_dec(b)) begin
                v = (hp == HP_DIG_W ? wacc : hacc) * 10 + longint'(b - psca_pkg::CH_ZERO);
                if (v > DIM_MAX) hdr_fail(psca_pkg::ERR_DIM);
                else if (hp == HP_DIG_W) wacc = v;
                else hacc = v;
                done = 1'b1;
              end else begin
                hp = hp + 4'd1;
              end
            end
            HP_DIG_M: begin
              if (is_dec(b)) begin
                v = mval * 10 + longint'(b - psca_pkg::CH_ZERO);
                mval = (mval > 6553 || v > 65535) ? 65535 : v;
              end else if (mval != longint'(psca_pkg::MAXVAL_OK)) begin
                hdr_fail(psca_pkg::ERR_MAXVAL);
              end else begin
                pix_left = wacc * hacc * 3;
                hp = HP_PIXELS;
              end
              done = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
    endcase

    if (!pix_out && !last) return 1'b0;
    r.has_pixel   = pix_out;
    r.pixel_value = pv;
    r.end_of_file = last;
    if (last) begin
      if (err_q != psca_pkg::ERR_NONE) st = err_q;
      else if (hp == HP_MAGIC0 || hp == HP_MAGIC1) st = psca_pkg::ERR_MAGIC;
      else if (hp != HP_PIXELS || pix_left != 0) st = psca_pkg::ERR_SIZE;
      else st = psca_pkg::ERR_NONE;
      r.status       = st;
      r.image_width  = wacc[15:0];
      r.image_height = hacc[15:0];
      hp = HP_MAGIC0;
      wacc = 0;
      hacc = 0;
      mval = 0;
      pix_left = 0;
      err_q = psca_pkg::ERR_NONE;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // result side: check each beat, then pick the next ready value
  always @(posedge clk) begin
    psca_pkg::pix_beat_t e;
    psca_pkg::pix_beat_t a;
    int g;
    if (!rst && pixels_if.valid && pixels_if.ready) begin
      a = pixels_if.data;
      if (pix_expect.size() == 0) begin
        $error("unexpected beat: pixel_value %0d end_of_file %0d status %0d",
               a.pixel_value, a.end_of_file, a.status);
        err_cnt++;
      end else begin
        e = pix_expect.pop_front();
        check_field("has_pixel", e.has_pixel, a.has_pixel);
        check_field("pixel_value", e.pixel_value, a.pixel_value);
        check_field("end_of_file", e.end_of_file, a.end_of_file);
        check_field("status", e.status, a.status);
        check_field("image_width", e.image_width, a.image_width);
        check_field("image_height", e.image_height, a.image_height);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pixels_if.ready <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left = g - 1;
        pixels_if.ready <= 1'b0;
      end else begin
        pixels_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed,
                           input psca_pkg::pix_beat_t fixed_beat);
    int                  gap;
    bit                  has;
    psca_pkg::pix_beat_t r;
    gap = pick_gap();
    if (gap > 0) begin
      file_bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    file_bytes_if.valid <= 1'b1;
    file_bytes_if.data  <= psca_pkg::byte_beat_t'{data_byte: b, is_last: last};
    do @(posedge clk); while (!file_bytes_if.ready);
    has = ppm_predict(b, last, r);
    if (fixed) pix_expect.push_back(fixed_beat);
    else if (has) pix_expect.push_back(r);
  endtask

  function automatic void add_row(logic [7:0] b, logic last, bit fixed,
                                  psca_pkg::pix_beat_t beat);
    dir_row_t row;
    row.b = b;
    row.last = last;
    row.fixed = fixed;
    row.beat = beat;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_bytes(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endfunction

  function automatic void push_num(longint unsigned n, int zeros);
    string s;
    int    i;
    s = $sformatf("%0d", n);
    repeat (zeros) file_q.push_back(psca_pkg::CH_ZERO);
    for (i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  function automatic void push_ws(int min_n);
    repeat ($urandom_range(min_n, 2))
      file_q.push_back($urandom_range(0, 1) ? psca_pkg::CH_SPACE : psca_pkg::CH_NL);
  endfunction

  function automatic logic [7:0] rand_sep_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_dec(c) || c == psca_pkg::CH_SPACE || c == psca_pkg::CH_NL);
    return c;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(127, 128));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int lead_zeros();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // mostly well-formed files with random content; the rest broken or noise
  function automatic void build_file();
    int kind, w, h, cnt, hdr_len, idx;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      if ($urandom_range(0, 1)) begin
        file_q.push_back(psca_pkg::CH_MAGIC0);
        file_q.push_back(psca_pkg::CH_MAGIC1);
      end
      repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    w = $urandom_range(1, 5);
    h = $urandom_range(1, 4);
    case ($urandom_range(0, 19))
      0: w = 0;
      1: h = 0;
      2: begin w = 65535; h = 0; end
      3: begin w = 0; h = 65535; end
      default: ;
    endcase
    file_q.push_back(psca_pkg::CH_MAGIC0);
    file_q.push_back(psca_pkg::CH_MAGIC1);
    push_ws(0);
    if (kind >= 76 && kind < 80) push_num($urandom_range(65536, 9999999), 0);
    else push_num(w, lead_zeros());
    push_ws(1);
    if (kind >= 76 && kind < 80 && $urandom_range(0, 1)) push_num($urandom_range(65536, 999999), 0);
    else push_num(h, lead_zeros());
    push_ws(1);
    if (kind >= 70 && kind < 76) begin
      case ($urandom_range(0, 4))
        0: push_num(254, 0);
        1: push_num(256, lead_zeros());
        2: ;
        3: push_num(99999999, 0);
        default: push_num($urandom_range(0, 65535), 0);
      endcase
    end else begin
      push_num(255, lead_zeros());
    end
    if ($urandom_range(0, 3) == 0) file_q.push_back(rand_sep_char());
    else file_q.push_back($urandom_range(0, 1) ? psca_pkg::CH_SPACE : psca_pkg::CH_NL);
    hdr_len = file_q.size();
    cnt = w * h * 3;
    if (kind >= 60 && kind < 65 && cnt > 0) cnt -= $urandom_range(1, cnt);
    if (kind >= 65 && kind < 70) cnt += $urandom_range(1, 3);
    repeat (cnt) file_q.push_back(rand_pixel());
    if (kind >= 80 && kind < 84) begin
      idx = $urandom_range(0, 1);
      file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 84 && kind < 88) begin
      idx = $urandom_range(1, hdr_len - 1);
      while (file_q.size() > idx) void'(file_q.pop_back());
    end else if (kind >= 88) begin
      idx = $urandom_range(2, hdr_len - 1);
      file_q[idx] = rand_sep_char();
    end
  endfunction

  task automatic wait_idle();
    while (pix_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ph, sent, i;
    logic signed [psca_pkg::GAIN_W-1:0] gain_plan [PHASE_CNT];
    gain_plan = '{16'sh8000, 16'sd32767, 16'sd0, 16'sd256, -16'sd256, 16'sd384, 16'sd0, 16'sd0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    file_bytes_if.valid = 1'b0;
    file_bytes_if.data = '0;
    pixels_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // 1x1 image: extremes at unity gain, then one pixel too many
    add_bytes("P6 1\n1 255\n");
    add_row(8'd0, 1'b0, 1'b1,
            mk_beat(1'b1, 8'd0, 1'b0, psca_pkg::ERR_NONE, 16'd0, 16'd0));
    add_row(8'd255, 1'b0, 1'b1,
            mk_beat(1'b1, 8'd255, 1'b0, psca_pkg::ERR_NONE, 16'd0, 16'd0));
    add_row(8'd128, 1'b0, 1'b1,
            mk_beat(1'b1, 8'd128, 1'b0, psca_pkg::ERR_NONE, 16'd0, 16'd0));
    add_row(8'd0, 1'b1, 1'b1,
            mk_beat(1'b0, 8'd0, 1'b1, psca_pkg::ERR_SIZE, 16'd1, 16'd1));
    // junk byte right after the magic ends all three fields
    add_bytes("P6");
    add_row("x", 1'b1, 1'b1,
            mk_beat(1'b0, 8'd0, 1'b1, psca_pkg::ERR_MAXVAL, 16'd0, 16'd0));
    // file ends inside the magic
    add_row(psca_pkg::CH_MAGIC0, 1'b1, 1'b1,
            mk_beat(1'b0, 8'd0, 1'b1, psca_pkg::ERR_MAGIC, 16'd0, 16'd0));
    // file ends after the magic
    add_bytes("P6");
    add_row(psca_pkg::CH_SPACE, 1'b1, 1'b1,
            mk_beat(1'b0, 8'd0, 1'b1, psca_pkg::ERR_SIZE, 16'd0, 16'd0));
    // bad first magic byte, rest drained
    add_bytes("Q");
    add_row(psca_pkg::CH_MAGIC0, 1'b1, 1'b1,
            mk_beat(1'b0, 8'd0, 1'b1, psca_pkg::ERR_MAGIC, 16'd0, 16'd0));

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].fixed,
                                    dir_rows[i].beat);
    file_bytes_if.valid <= 1'b0;

    for (ph = 0; ph < PHASE_CNT; ph++) begin
      wait_idle();
      if (ph == 6) gain_plan[ph] = 16'($urandom_range(0, 65535));
      if (ph == 7) gain_plan[ph] = 16'($urandom_range(0, 2047) - 1024);
      cfg_we    <= 1'b1;
      cfg_wdata <= gain_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      gain_q = gain_plan[ph];
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_file();
        calm = ($urandom_range(0, 9) == 0);
        for (i = 0; i < file_q.size(); i++)
          send_byte(file_q[i], i == file_q.size() - 1, 1'b0, '0);
        sent += file_q.size();
      end
      calm = 1'b0;
      file_bytes_if.valid <= 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== ppm_stream_contrast_adjust.f =====
src/psca_pkg.sv
src/psca_ifs.sv
src/psca_pixel_adjust.sv
src/ppm_stream_contrast_adjust.sv
src/psca_checker.sv
verif/tb_ppm_stream_contrast_adjust.sv
